// ----- hw/rtl/assert_macros.svh -----
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge except while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- hw/rtl/obagg_pkg.sv -----
package obagg_pkg;

   localparam int BARS_PER_GROUP = 6;
   localparam int BARS_PER_DAY   = 48;
   localparam int DAY_GAP        = 720;

   localparam int PRICE_W  = 32;
   localparam int VALUE_W  = 28;
   localparam int MAGIC_W  = VALUE_W + 1;
   localparam int PROD_W   = VALUE_W + MAGIC_W;
   localparam int GROUP_W  = 3;
   localparam int DAYCNT_W = 6;

   // Divisor codes in the top nibble of a volume word.
   localparam logic [3:0] VCODE_DIV100    = 4'h0;
   localparam logic [3:0] VCODE_DIV10     = 4'h1;
   localparam logic [3:0] VCODE_DIV1      = 4'h2;
   localparam logic [3:0] VCODE_DIV1000   = 4'h9;
   localparam logic [3:0] VCODE_DIV10000  = 4'hA;
   localparam logic [3:0] VCODE_DIV100000 = 4'hB;

   // Exact reciprocals for a 28-bit dividend: m = ceil(2^(28+l) / d), l = ceil(log2 d).
   localparam int SH_DIV10     = VALUE_W + 4;
   localparam int SH_DIV100    = VALUE_W + 7;
   localparam int SH_DIV1000   = VALUE_W + 10;
   localparam int SH_DIV10000  = VALUE_W + 14;
   localparam int SH_DIV100000 = VALUE_W + 17;

   localparam logic [MAGIC_W-1:0] MAGIC_DIV10 =
      MAGIC_W'(((64'd1 << SH_DIV10) + 64'd9) / 64'd10);
   localparam logic [MAGIC_W-1:0] MAGIC_DIV100 =
      MAGIC_W'(((64'd1 << SH_DIV100) + 64'd99) / 64'd100);
   localparam logic [MAGIC_W-1:0] MAGIC_DIV1000 =
      MAGIC_W'(((64'd1 << SH_DIV1000) + 64'd999) / 64'd1000);
   localparam logic [MAGIC_W-1:0] MAGIC_DIV10000 =
      MAGIC_W'(((64'd1 << SH_DIV10000) + 64'd9999) / 64'd10000);
   localparam logic [MAGIC_W-1:0] MAGIC_DIV100000 =
      MAGIC_W'(((64'd1 << SH_DIV100000) + 64'd99999) / 64'd100000);
   localparam logic [MAGIC_W-1:0] MAGIC_DIV1 = MAGIC_W'(1);

   localparam int REQ_DATA_W = 6 * PRICE_W;
   localparam int RSP_DATA_W = 168;

   typedef struct packed {
      logic [PRICE_W-1:0] minute_stamp;
      logic [PRICE_W-1:0] open_raw;
      logic [PRICE_W-1:0] high_raw;
      logic [PRICE_W-1:0] low_raw;
      logic [PRICE_W-1:0] close_raw;
      logic [PRICE_W-1:0] volume_word;
      logic               day_start;
   } bar_type;

   typedef struct packed {
      logic [PRICE_W-1:0] bar_open;
      logic [PRICE_W-1:0] bar_high;
      logic [PRICE_W-1:0] bar_low;
      logic [PRICE_W-1:0] bar_close;
      logic [PRICE_W-1:0] bar_volume;
      logic [GROUP_W-1:0] bar_number;
      logic               bad_volume_code;
   } result_type;

endpackage

// ----- hw/rtl/ohlcv_bar_aggregator_core.sv -----
// Merges a stream of 5-minute OHLCV bars into 30-minute bars, six bars to a group.
// Input beats arrive on req_* and carry one bar each; day_start travels on req_tuser.
// A finished 30-minute bar leaves on rsp_* with the unknown-divisor flag on rsp_tuser.
// The price offset is written on csr_* (always ready) and must only change while the
// block is idle.
// A bar that completes a group passes the input register, the volume multiply register
// and the result register in that order before rsp_tvalid rises; a full skid entry
// can hold it in the volume multiply register.
// Throughput: one bar per cycle unless stalled; the single 28x29 reciprocal
// multiply and the accumulate stage keep pace. Five bars of six produce no result.
// A two-entry output (result register plus skid register) decouples the sides:
// req_tready depends only on internal registers, so a stalled receiver blocks the
// input only once the skid entry is full and both pipeline registers hold a bar.
// Reset clears the pipeline, the day and group counters, the error flag and the
// price offset; the first bar after reset always opens a new trading day.
module ohlcv_bar_aggregator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // minute_stamp, open_raw, high_raw, low_raw, close_raw, volume_word
   input  logic [obagg_pkg::REQ_DATA_W-1:0] req_tdata,
   // day_start
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // bar_open, bar_high, bar_low, bar_close, bar_volume, bar_number, zero padding
   output logic [obagg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bad_volume_code
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [obagg_pkg::PRICE_W-1:0]   csr_data
);
   import obagg_pkg::*;

   logic [PRICE_W-1:0] offset_ff;

   // Pipeline registers.
   logic               s1_valid_ff, s1_valid_in;
   bar_type            s1_bar_ff;
   logic               s2_valid_ff, s2_valid_in;
   bar_type            s2_bar_ff;
   logic [PROD_W-1:0]  s2_prod_ff;

   // Aggregation state.
   logic [PRICE_W-1:0]  prev_stamp_ff, prev_stamp_in;
   logic                day_open_ff, day_open_in;
   logic [GROUP_W-1:0]  in_group_ff, in_group_in;
   logic [DAYCNT_W-1:0] today_ff, today_in;
   logic [GROUP_W-1:0]  group_num_ff, group_num_in;
   logic [PRICE_W-1:0]  run_high_ff, run_high_in;
   logic [PRICE_W-1:0]  run_low_ff, run_low_in;
   logic [PRICE_W-1:0]  run_vol_ff, run_vol_in;
   logic [PRICE_W-1:0]  group_open_ff, group_open_in;
   logic                vol_err_ff, vol_err_in;

   // Output register and skid register.
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;

   logic               consume, s2_load, s1_load, push;
   logic [MAGIC_W-1:0] magic;
   logic [VALUE_W-1:0] vol_dec;
   logic               vol_bad;
   result_type         res;

   bar_type req_bar;

   assign req_bar = '{
      minute_stamp: req_tdata[0 +: PRICE_W],
      open_raw:     req_tdata[PRICE_W +: PRICE_W],
      high_raw:     req_tdata[2*PRICE_W +: PRICE_W],
      low_raw:      req_tdata[3*PRICE_W +: PRICE_W],
      close_raw:    req_tdata[4*PRICE_W +: PRICE_W],
      volume_word:  req_tdata[5*PRICE_W +: PRICE_W],
      day_start:    req_tuser
   };

   assign csr_ready = 1'b1;

   // The merge stage waits only for the skid entry, so no path runs from rsp_tready.
   assign consume    = s2_valid_ff && !skid_valid_ff;
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || consume);
   assign req_tready = !s1_valid_ff || !s2_valid_ff || consume;
   assign s1_load    = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (consume) begin
         s2_valid_in = 1'b0;
      end
   end

   // Reciprocal for the divisor code of the bar in the input register.
   always_comb begin
      unique case (s1_bar_ff.volume_word[31:28])
         VCODE_DIV100:    magic = MAGIC_DIV100;
         VCODE_DIV10:     magic = MAGIC_DIV10;
         VCODE_DIV1000:   magic = MAGIC_DIV1000;
         VCODE_DIV10000:  magic = MAGIC_DIV10000;
         VCODE_DIV100000: magic = MAGIC_DIV100000;
         default:         magic = MAGIC_DIV1;
      endcase
   end

   // Quotient taken from the registered product.
   always_comb begin
      vol_bad = 1'b0;
      unique case (s2_bar_ff.volume_word[31:28])
         VCODE_DIV100:    vol_dec = VALUE_W'(s2_prod_ff >> SH_DIV100);
         VCODE_DIV10:     vol_dec = VALUE_W'(s2_prod_ff >> SH_DIV10);
         VCODE_DIV1:      vol_dec = VALUE_W'(s2_prod_ff);
         VCODE_DIV1000:   vol_dec = VALUE_W'(s2_prod_ff >> SH_DIV1000);
         VCODE_DIV10000:  vol_dec = VALUE_W'(s2_prod_ff >> SH_DIV10000);
         VCODE_DIV100000: vol_dec = VALUE_W'(s2_prod_ff >> SH_DIV100000);
         default: begin
            vol_dec = VALUE_W'(s2_prod_ff);
            vol_bad = 1'b1;
         end
      endcase
   end

   // Merge stage: day break, day limit and group accumulation.
   always_comb begin
      logic                brk;
      logic [PRICE_W-1:0]  gap;
      logic [GROUP_W:0]    in_group_inc;

      prev_stamp_in = prev_stamp_ff;
      day_open_in   = day_open_ff;
      in_group_in   = in_group_ff;
      today_in      = today_ff;
      group_num_in  = group_num_ff;
      run_high_in   = run_high_ff;
      run_low_in    = run_low_ff;
      run_vol_in    = run_vol_ff;
      group_open_in = group_open_ff;
      vol_err_in    = vol_err_ff;
      push          = 1'b0;
      res           = '0;
      in_group_inc  = '0;

      gap = s2_bar_ff.minute_stamp - prev_stamp_ff;
      brk = s2_bar_ff.day_start || !day_open_ff || (gap > PRICE_W'(DAY_GAP));

      if (consume) begin
         prev_stamp_in = s2_bar_ff.minute_stamp;
         day_open_in   = 1'b1;
         if (brk) begin
            in_group_in  = '0;
            today_in     = '0;
            group_num_in = '0;
            run_high_in  = '0;
            run_low_in   = '1;
            run_vol_in   = '0;
         end

         // A bar beyond the day's limit only moves the stamp on.
         if (today_in < DAYCNT_W'(BARS_PER_DAY)) begin
            today_in = today_in + DAYCNT_W'(1);
            if (s2_bar_ff.high_raw > run_high_in) begin
               run_high_in = s2_bar_ff.high_raw;
            end
            if (s2_bar_ff.low_raw < run_low_in) begin
               run_low_in = s2_bar_ff.low_raw;
            end
            vol_err_in = vol_err_ff || vol_bad;
            run_vol_in = run_vol_in + PRICE_W'(vol_dec);
            if (in_group_in == '0) begin
               group_open_in = s2_bar_ff.open_raw - offset_ff;
            end

            in_group_inc = {1'b0, in_group_in} + (GROUP_W + 1)'(1);
            if (in_group_inc >= (GROUP_W + 1)'(BARS_PER_GROUP)) begin
               push                = 1'b1;
               res.bar_open        = group_open_in;
               res.bar_high        = run_high_in - offset_ff;
               res.bar_low         = run_low_in - offset_ff;
               res.bar_close       = s2_bar_ff.close_raw - offset_ff;
               res.bar_volume      = run_vol_in + PRICE_W'(3);
               res.bar_number      = group_num_in;
               res.bad_volume_code = vol_err_in;
               group_num_in        = group_num_in + GROUP_W'(1);
               vol_err_in          = 1'b0;
               in_group_in         = '0;
               run_high_in         = '0;
               run_low_in          = '1;
               run_vol_in          = '0;
            end else begin
               in_group_in = GROUP_W'(in_group_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         prev_stamp_ff <= '0;
         day_open_ff   <= 1'b0;
         in_group_ff   <= '0;
         today_ff      <= '0;
         group_num_ff  <= '0;
         run_high_ff   <= '0;
         run_low_ff    <= '1;
         run_vol_ff    <= '0;
         group_open_ff <= '0;
         vol_err_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_data;
         end
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         prev_stamp_ff <= prev_stamp_in;
         day_open_ff   <= day_open_in;
         in_group_ff   <= in_group_in;
         today_ff      <= today_in;
         group_num_ff  <= group_num_in;
         run_high_ff   <= run_high_in;
         run_low_ff    <= run_low_in;
         run_vol_ff    <= run_vol_in;
         group_open_ff <= group_open_in;
         vol_err_ff    <= vol_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_bar_ff <= req_bar;
      end
      if (s2_load) begin
         s2_bar_ff  <= s1_bar_ff;
         s2_prod_ff <= PROD_W'(s1_bar_ff.volume_word[VALUE_W-1:0]) * PROD_W'(magic);
      end
   end

   // Output register with a skid entry behind it. A new result is only pushed
   // while the skid entry is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= res;
         end
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 5*PRICE_W - GROUP_W)'(0),
                        out_ff.bar_number, out_ff.bar_volume, out_ff.bar_close,
                        out_ff.bar_low, out_ff.bar_high, out_ff.bar_open};
   assign rsp_tuser  = out_ff.bad_volume_code;

endmodule

// ----- hw/rtl/obagg_checker.sv -----
`include "assert_macros.svh"

module obagg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [obagg_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [obagg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [obagg_pkg::PRICE_W-1:0]   csr_data
);
   import obagg_pkg::*;

   logic unused_ok;
   assign unused_ok = req_tvalid ^ (^req_tdata) ^ req_tuser ^ csr_valid ^ csr_ready ^
                      (^csr_data);

   // The pipeline is empty after reset, so no result can be pending.
   `ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_tvalid, "result valid after reset")

   // An empty pipeline always takes a beat.
   `ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_tready, "input not ready after reset")

   `ASSERT_CLK(a_rsp_valid_holds, rsp_tvalid && !rsp_tready |=> rsp_tvalid,
               "result withdrawn while stalled")

   `ASSERT_CLK(a_rsp_data_holds,
               rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser),
               "result changed while stalled")

endmodule

bind ohlcv_bar_aggregator_core obagg_checker u_obagg_checker (.*);
